>>> src/qau_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, operation codes, the item record that travels down the
// pipeline and the saturation helper.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SQ_W       = 2 * DATA_W;
    localparam int ROOT_W     = DATA_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int QUO_W      = DATA_W + 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int NORM_SH    = FRAC_BITS + 1;
    localparam int INV_SH     = 3 * FRAC_BITS + 1;

    localparam logic [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KIND_MUL,
        KIND_ADD,
        KIND_SUB,
        KIND_SCALE,
        KIND_CONJ,
        KIND_MAG,
        KIND_NORM,
        KIND_INV
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_SAT,
        STATUS_ZERO,
        STATUS_RSVD
    } status_t;

    // One item in flight. For normalize and inverse, r holds the component
    // magnitudes and neg the signs of the final results.
    typedef struct packed {
        kind_t                   kind;
        logic [3:0][DATA_W-1:0]  r;
        logic [3:0]              neg;
        logic                    sat;
        logic [SQ_W-1:0]         sq;
        logic [ROOT_W-1:0]       root;
    } qau_item_t;

    // Clamp a wide signed value to the result range; the top bit flags clamping.
    function automatic logic [DATA_W:0] clamp_word(input logic [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] upper;
        upper = v[SUM_W-1:DATA_W-1];
        if ((upper == '0) || (upper == '1)) begin
            clamp_word = {1'b0, v[DATA_W-1:0]};
        end else if (v[SUM_W-1]) begin
            clamp_word = {1'b1, RES_MIN};
        end else begin
            clamp_word = {1'b1, RES_MAX};
        end
    endfunction

endpackage

>>> src/qau_front.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit front end
// Input register, sixteen multipliers, partial sums and final rounding for
// multiply and scale, plus add, subtract, conjugate and sum of squares.
// ----------------------------------------------------------------------------
module qau_front
    import qau_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0]                  in_kind,
    input  logic [3:0][DATA_W-1:0]      in_a,
    input  logic [3:0][DATA_W-1:0]      in_b,
    input  logic [DATA_W-1:0]           in_factor,
    output logic                        out_valid,
    output qau_item_t                   out_item
);

    // Stage 0: input register.
    logic                   v0_reg;
    kind_t                  kind0_reg;
    logic [3:0][DATA_W-1:0] a0_reg;
    logic [3:0][DATA_W-1:0] b0_reg;
    logic [DATA_W-1:0]      f0_reg;

    // Stage 1: products and the simple operations.
    logic                   v1_reg;
    qau_item_t              item1_reg;
    qau_item_t              item1_next;
    logic signed [PROD_W-1:0] prod_reg  [4][4];
    logic signed [PROD_W-1:0] prod_next [4][4];

    // Stage 2: pairwise sums.
    logic                   v2_reg;
    qau_item_t              item2_reg;
    logic signed [PROD_W:0] lo_reg  [4];
    logic signed [PROD_W:0] hi_reg  [4];
    logic signed [PROD_W:0] lo_next [4];
    logic signed [PROD_W:0] hi_next [4];
    logic [PROD_W:0]        sqa_reg;
    logic [PROD_W:0]        sqb_reg;
    logic [PROD_W:0]        sqa_next;
    logic [PROD_W:0]        sqb_next;

    // Stage 3: rounded and clamped results.
    logic                   v3_reg;
    qau_item_t              item3_reg;
    qau_item_t              item3_next;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            kind0_reg <= kind_t'(in_kind);
            a0_reg    <= in_a;
            b0_reg    <= in_b;
            f0_reg    <= in_factor;
            item1_reg <= item1_next;
            item2_reg <= item1_reg;
            sqa_reg   <= sqa_next;
            sqb_reg   <= sqb_next;
            item3_reg <= item3_next;
            for (int i = 0; i < 4; i++) begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= prod_next[i][j];
                end
            end
        end
    end

    // Products: B for multiply, the factor for scale, A itself for squares.
    always_comb begin
        logic [DATA_W-1:0] opb [4];
        for (int j = 0; j < 4; j++) begin
            if (kind0_reg == KIND_MUL) begin
                opb[j] = b0_reg[j];
            end else if (kind0_reg == KIND_SCALE) begin
                opb[j] = f0_reg;
            end else begin
                opb[j] = a0_reg[j];
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod_next[i][j] = $signed(a0_reg[i]) * $signed(opb[j]);
            end
        end
    end

    // Add, subtract, conjugate, and magnitudes with signs for the dividers.
    always_comb begin
        logic [DATA_W:0]   ext_a;
        logic [DATA_W:0]   ext_b;
        logic [DATA_W:0]   wide;
        logic [DATA_W:0]   cw;
        item1_next      = '0;
        item1_next.kind = kind0_reg;
        for (int i = 0; i < 4; i++) begin
            ext_a = {a0_reg[i][DATA_W-1], a0_reg[i]};
            ext_b = {b0_reg[i][DATA_W-1], b0_reg[i]};
            wide  = ext_a;
            case (kind0_reg)
                KIND_ADD: wide = ext_a + ext_b;
                KIND_SUB: wide = ext_a - ext_b;
                KIND_CONJ: begin
                    if (i != 0) begin
                        wide = '0 - ext_a;
                    end
                end
                default: wide = ext_a;
            endcase
            cw = clamp_word({{(SUM_W-DATA_W-1){wide[DATA_W]}}, wide});
            case (kind0_reg)
                KIND_ADD, KIND_SUB, KIND_CONJ: begin
                    item1_next.r[i] = cw[DATA_W-1:0];
                    if (cw[DATA_W]) begin
                        item1_next.sat = 1'b1;
                    end
                end
                KIND_NORM, KIND_INV: begin
                    item1_next.r[i] = a0_reg[i][DATA_W-1] ? ('0 - a0_reg[i]) : a0_reg[i];
                    if ((kind0_reg == KIND_INV) && (i != 0)) begin
                        item1_next.neg[i] = !a0_reg[i][DATA_W-1];
                    end else begin
                        item1_next.neg[i] = a0_reg[i][DATA_W-1];
                    end
                end
                default: item1_next.r[i] = '0;
            endcase
        end
    end

    // Pairwise sums of the Hamilton product terms and of the squares.
    always_comb begin
        logic signed [PROD_W:0] p [4][4];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i][j] = {prod_reg[i][j][PROD_W-1], prod_reg[i][j]};
            end
        end
        if (item1_reg.kind == KIND_MUL) begin
            lo_next[0] = p[0][0] - p[1][1];
            hi_next[0] = -p[2][2] - p[3][3];
            lo_next[1] = p[0][1] + p[1][0];
            hi_next[1] = p[2][3] - p[3][2];
            lo_next[2] = p[0][2] - p[1][3];
            hi_next[2] = p[2][0] + p[3][1];
            lo_next[3] = p[0][3] + p[1][2];
            hi_next[3] = p[3][0] - p[2][1];
        end else begin
            for (int i = 0; i < 4; i++) begin
                lo_next[i] = p[i][i];
                hi_next[i] = '0;
            end
        end
        sqa_next = {1'b0, prod_reg[0][0]} + {1'b0, prod_reg[1][1]};
        sqb_next = {1'b0, prod_reg[2][2]} + {1'b0, prod_reg[3][3]};
    end

    // Final sums, rounding half up and clamping; saturating sum of squares.
    always_comb begin
        logic signed [SUM_W-1:0] tot;
        logic signed [SUM_W-1:0] shifted;
        logic [DATA_W:0]         cw;
        logic [PROD_W+1:0]       sq_sum;
        item3_next = item2_reg;
        for (int i = 0; i < 4; i++) begin
            tot = {lo_reg[i][PROD_W], lo_reg[i]} + {hi_reg[i][PROD_W], hi_reg[i]}
                + SUM_W'(1 << (FRAC_BITS - 1));
            shifted = tot >>> FRAC_BITS;
            cw = clamp_word(shifted);
            if ((item2_reg.kind == KIND_MUL) || (item2_reg.kind == KIND_SCALE)) begin
                item3_next.r[i] = cw[DATA_W-1:0];
                if (cw[DATA_W]) begin
                    item3_next.sat = 1'b1;
                end
            end
        end
        sq_sum = {1'b0, sqa_reg} + {1'b0, sqb_reg};
        if (sq_sum[PROD_W+1:SQ_W] != '0) begin
            item3_next.sq = '1;
        end else begin
            item3_next.sq = sq_sum[SQ_W-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

>>> src/qau_sqrt.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit square root
// Pipelined restoring integer square root of the sum of squares, one root
// bit per stage.
// ----------------------------------------------------------------------------
module qau_sqrt
    import qau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  qau_item_t   in_item,
    output logic        out_valid,
    output qau_item_t   out_item
);

    logic [SQRT_STEPS-1:0] valid_reg;
    qau_item_t             item_reg [SQRT_STEPS];
    logic [REM_W-1:0]      rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0]     root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam int PAIR = 2 * (SQRT_STEPS - 1 - k);

        logic              v_in;
        qau_item_t         item_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign item_in = item_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down the next two bits and try to subtract 4*root+1.
        always_comb begin
            shifted = {rem_in[REM_W-3:0], item_in.sq[PAIR +: 2]};
            trial   = {1'b0, root_in, 2'b01};
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[k] <= item_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    // Attach the finished root to the item.
    always_comb begin
        out_item      = item_reg[SQRT_STEPS-1];
        out_item.root = root_reg[SQRT_STEPS-1];
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];

endmodule

>>> src/qau_div.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit divider
// Setup stage that picks the divisor and the magnitude result, then four
// pipelined restoring dividers, one quotient bit per stage, with an early
// overflow flag per lane.
// ----------------------------------------------------------------------------
module qau_div
    import qau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  qau_item_t               in_item,
    output logic                    out_valid,
    output qau_item_t               out_item,
    output logic [3:0][QUO_W-1:0]   out_quo,
    output logic [3:0]              out_big
);

    logic [DIV_STEPS:0]       valid_reg;
    qau_item_t                item_reg [DIV_STEPS+1];
    logic [SQ_W-1:0]          d_reg    [DIV_STEPS+1];
    logic [3:0]               big_reg  [DIV_STEPS+1];
    logic [3:0][SQ_W-1:0]     rem_reg  [DIV_STEPS+1];
    logic [3:0][QUO_W-1:0]    quo_reg  [DIV_STEPS+1];

    qau_item_t                item_s;
    logic [SQ_W-1:0]          d_s;
    logic [3:0]               big_s;
    logic [3:0][SQ_W-1:0]     rem_s;

    // Setup: divisor is the root for normalize and the sum of squares for
    // inverse; the numerator's top part seeds the remainder.
    always_comb begin
        logic [SQ_W-1:0] upper;
        item_s = in_item;
        if (in_item.kind == KIND_MAG) begin
            item_s.r[0] = in_item.root[ROOT_W-1] ? RES_MAX : in_item.root;
            item_s.sat  = in_item.root[ROOT_W-1];
        end
        if (in_item.kind == KIND_NORM) begin
            d_s = {{(SQ_W-ROOT_W){1'b0}}, in_item.root};
        end else begin
            d_s = in_item.sq;
        end
        for (int i = 0; i < 4; i++) begin
            if (in_item.kind == KIND_NORM) begin
                upper = {{(SQ_W-DATA_W){1'b0}}, in_item.r[i] >> (DIV_STEPS - NORM_SH)};
            end else begin
                upper = {{(SQ_W-DATA_W){1'b0}}, in_item.r[i]} << (INV_SH - DIV_STEPS);
            end
            big_s[i] = (upper >= d_s);
            rem_s[i] = upper;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= item_s;
            d_reg[0]    <= d_s;
            big_reg[0]  <= big_s;
            rem_reg[0]  <= rem_s;
            quo_reg[0]  <= '0;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        localparam int  BITPOS  = DIV_STEPS - s;
        localparam bit  HAS_BIT = (BITPOS >= NORM_SH);
        localparam int  NIDX    = HAS_BIT ? (BITPOS - NORM_SH) : 0;

        logic [3:0][SQ_W-1:0]  rem_next;
        logic [3:0][QUO_W-1:0] quo_next;

        // Shift in the next numerator bit and subtract the divisor if it fits.
        always_comb begin
            logic          nbit;
            logic [SQ_W:0] trial;
            for (int i = 0; i < 4; i++) begin
                nbit = HAS_BIT && (item_reg[s-1].kind == KIND_NORM)
                    && item_reg[s-1].r[i][NIDX];
                trial = {rem_reg[s-1][i], nbit};
                if (trial >= {1'b0, d_reg[s-1]}) begin
                    trial       = trial - {1'b0, d_reg[s-1]};
                    quo_next[i] = {quo_reg[s-1][i][QUO_W-2:0], 1'b1};
                end else begin
                    quo_next[i] = {quo_reg[s-1][i][QUO_W-2:0], 1'b0};
                end
                rem_next[i] = trial[SQ_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[s] <= item_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
                big_reg[s]  <= big_reg[s-1];
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_item  = item_reg[DIV_STEPS];
    assign out_quo   = quo_reg[DIV_STEPS];
    assign out_big   = big_reg[DIV_STEPS];

endmodule

>>> src/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Signed Q16.16 quaternion ALU: product, sum, difference, scale, conjugate,
// magnitude, normalize and inverse, with saturation and status.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the s_ channel (s_valid/s_ready) with an operation code,
// quaternions A and B and a scale factor. Each item gives exactly one result
// on the m_ channel (m_valid/m_ready): the four result components and a
// status (0 ok, 1 saturated, 2 zero magnitude in normalize or inverse).
// Every operation runs through the same pipeline, so results leave in order.
// From acceptance to m_valid an item passes four front stages
// (input register, multipliers, two adder stages), 32 square root stages at
// one root bit each, a divider setup stage, 34 divider stages at one
// quotient bit each, and the output register. Throughput is one item per
// cycle unless the receiver stalls: when it holds m_ready low with a result
// waiting, the whole pipeline holds and s_ready falls; nothing is lost or
// repeated. Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
    import qau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_kind,
    input  logic signed [31:0]  s_a_w,
    input  logic signed [31:0]  s_a_x,
    input  logic signed [31:0]  s_a_y,
    input  logic signed [31:0]  s_a_z,
    input  logic signed [31:0]  s_b_w,
    input  logic signed [31:0]  s_b_x,
    input  logic signed [31:0]  s_b_y,
    input  logic signed [31:0]  s_b_z,
    input  logic signed [31:0]  s_factor,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_r_w,
    output logic signed [31:0]  m_r_x,
    output logic signed [31:0]  m_r_y,
    output logic signed [31:0]  m_r_z,
    output logic [1:0]          m_status
);

    logic                    en;
    logic                    front_valid;
    qau_item_t               front_item;
    logic                    sqrt_valid;
    qau_item_t               sqrt_item;
    logic                    div_valid;
    qau_item_t               div_item;
    logic [3:0][QUO_W-1:0]   div_quo;
    logic [3:0]              div_big;

    logic                    m_valid_reg;
    logic [3:0][DATA_W-1:0]  res_reg;
    logic [3:0][DATA_W-1:0]  res_next;
    status_t                 status_reg;
    status_t                 status_next;

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_kind   (s_kind),
        .in_a      ({s_a_z, s_a_y, s_a_x, s_a_w}),
        .in_b      ({s_b_z, s_b_y, s_b_x, s_b_w}),
        .in_factor (s_factor),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    qau_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item)
    );

    qau_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_item   (sqrt_item),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_quo   (div_quo),
        .out_big   (div_big)
    );

    // Round the quotients half up, apply signs and clamp; pick the status.
    always_comb begin
        logic [QUO_W:0]    q_wide;
        logic [QUO_W-1:0]  q;
        logic              sat;
        logic              over;
        q_wide   = '0;
        q        = '0;
        over     = 1'b0;
        res_next = div_item.r;
        sat      = div_item.sat;
        if ((div_item.kind == KIND_NORM) || (div_item.kind == KIND_INV)) begin
            for (int i = 0; i < 4; i++) begin
                q_wide = {1'b0, div_quo[i]} + 1'b1;
                q      = q_wide[QUO_W:1];
                if (div_item.neg[i]) begin
                    over = div_big[i] || (q[QUO_W-1:DATA_W] != '0)
                        || (q[DATA_W-1] && (q[DATA_W-2:0] != '0));
                    res_next[i] = over ? RES_MIN : ('0 - q[DATA_W-1:0]);
                end else begin
                    over = div_big[i] || (q[QUO_W-1:DATA_W-1] != '0);
                    res_next[i] = over ? RES_MAX : q[DATA_W-1:0];
                end
                if (over) begin
                    sat = 1'b1;
                end
            end
            if (div_item.sq == '0) begin
                res_next = '0;
            end
        end
        if (((div_item.kind == KIND_NORM) || (div_item.kind == KIND_INV))
            && (div_item.sq == '0)) begin
            status_next = STATUS_ZERO;
        end else if (sat) begin
            status_next = STATUS_SAT;
        end else begin
            status_next = STATUS_OK;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_r_w    = res_reg[0];
    assign m_r_x    = res_reg[1];
    assign m_r_y    = res_reg[2];
    assign m_r_z    = res_reg[3];
    assign m_status = status_reg;

endmodule

>>> dv/tb_quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives directed and random items through the valid/ready input channel with
// random gaps, predicts each result with an independent fixed point model and
// checks every field of every result in order. The receiver stalls at random,
// including one long hold-off, and the sender drains the pipeline partway and at the end.
// ----------------------------------------------------------------------------
module tb_quaternion_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import qau_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 450;

    // One input item and one result item.
    typedef struct {
        kind_t                    kind;
        logic signed [31:0]       a [4];
        logic signed [31:0]       b [4];
        logic signed [31:0]       factor;
    } quat_op_t;

    typedef struct {
        logic signed [31:0]       r [4];
        status_t                  status;
    } quat_res_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        error_count++;
        $display("mismatch in %s: got %0h expected %0h", what, got, exp_v);
    endtask

    // ------------------------------------------------------------------------
    // Arithmetic helpers for the predictor.
    // ------------------------------------------------------------------------
    function automatic logic signed [95:0] sat_word(input logic signed [95:0] v,
                                                    inout logic sat);
        if (v > 96'sd2147483647) begin
            sat = 1'b1;
            return 96'sd2147483647;
        end
        if (v < -96'sd2147483648) begin
            sat = 1'b1;
            return -96'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded signed quotient c * 2^sh / d with ties away from zero.
    function automatic logic signed [95:0] round_div(input logic signed [95:0] c,
                                                     input int sh,
                                                     input logic [95:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] rem;
        mag = (c < 0) ? -c : c;
        mag = mag << sh;
        q = mag / d;
        rem = mag % d;
        if (rem >= d - rem) q = q + 1;
        // Anything this large clamps anyway; keep it inside the working width.
        if (q > (128'd1 << 40)) q = (128'd1 << 40) + 1;
        return (c < 0) ? -$signed({1'b0, q[94:0]}) : $signed({1'b0, q[94:0]});
    endfunction

    // Predicts the result of one item.
    function automatic quat_res_t predict_quat(input quat_op_t op);
        quat_res_t res;
        logic signed [95:0] a [4];
        logic signed [95:0] b [4];
        logic signed [95:0] v [4];
        logic signed [95:0] f;
        logic [95:0] sumsq;
        logic [63:0] root;
        logic sat;
        logic zero_mag;
        sat = 0;
        zero_mag = 0;
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = op.a[i];
            b[i] = op.b[i];
            v[i] = 0;
            sumsq = sumsq + a[i] * a[i];
        end
        f = op.factor;
        if (sumsq > 96'hFFFF_FFFF_FFFF_FFFF) sumsq = 96'hFFFF_FFFF_FFFF_FFFF;
        case (op.kind)
            KIND_MUL: begin
                v[0] = (a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3] + 32768) >>> 16;
                v[1] = (a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2] + 32768) >>> 16;
                v[2] = (a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1] + 32768) >>> 16;
                v[3] = (a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0] + 32768) >>> 16;
            end
            KIND_ADD:   for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
            KIND_SUB:   for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
            KIND_SCALE: for (int i = 0; i < 4; i++) v[i] = (a[i] * f + 32768) >>> 16;
            KIND_CONJ: begin
                v[0] = a[0];
                for (int i = 1; i < 4; i++) v[i] = -a[i];
            end
            KIND_MAG: v[0] = int_sqrt(sumsq[63:0]);
            KIND_NORM: begin
                if (sumsq == 0) begin
                    zero_mag = 1;
                end else begin
                    root = int_sqrt(sumsq[63:0]);
                    for (int i = 0; i < 4; i++) v[i] = round_div(a[i], 16, root);
                end
            end
            default: begin
                if (sumsq == 0) begin
                    zero_mag = 1;
                end else begin
                    v[0] = round_div(a[0], 48, sumsq);
                    for (int i = 1; i < 4; i++) v[i] = round_div(-a[i], 48, sumsq);
                end
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            res.r[i] = zero_mag ? 32'sd0 : 32'(sat_word(v[i], sat));
        end
        res.status = zero_mag ? STATUS_ZERO : (sat ? STATUS_SAT : STATUS_OK);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predicted results in arrival order.
    // ------------------------------------------------------------------------
    class quat_scoreboard;
        quat_res_t pending_results[$];

        function void note_item(input quat_op_t op);
            pending_results.push_back(predict_quat(op));
        endfunction

        task check_result(input quat_res_t got);
            quat_res_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got.r[0], 0);
                return;
            end
            want = pending_results.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got.r[i] !== want.r[i]) begin
                    report_mismatch($sformatf("r[%0d]", i), got.r[i], want.r[i]);
                end
            end
            if (got.status !== want.status) begin
                report_mismatch("status", got.status, want.status);
            end
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic signed [31:0] s_a_w = 0, s_a_x = 0, s_a_y = 0, s_a_z = 0;
    logic signed [31:0] s_b_w = 0, s_b_x = 0, s_b_y = 0, s_b_z = 0;
    logic signed [31:0] s_factor = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_r_w, m_r_x, m_r_y, m_r_z;
    logic [1:0] m_status;

    quat_scoreboard scoreboard = new();
    bit long_hold_req = 0;
    bit stimulus_done = 0;
    int idle_cycles = 0;

    quaternion_arithmetic_unit i_dut (.*);

    // Clock generation.
    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
            3: return 0;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic quat_op_t rand_op();
        quat_op_t op;
        op.kind = kind_t'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++) begin
            op.a[i] = rand_word();
            op.b[i] = rand_word();
        end
        op.factor = rand_word();
        return op;
    endfunction

    function automatic quat_op_t make_op(input kind_t k, input logic signed [31:0] av,
                                         input logic signed [31:0] bv,
                                         input logic signed [31:0] fv);
        quat_op_t op;
        op.kind = k;
        for (int i = 0; i < 4; i++) begin
            op.a[i] = av;
            op.b[i] = bv;
        end
        op.factor = fv;
        return op;
    endfunction

    // Offers one item after a random gap and waits until it is accepted.
    // Valid stays high after acceptance until the next gap or a drain.
    task automatic send_item(input quat_op_t op);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_kind <= op.kind;
        {s_a_w, s_a_x, s_a_y, s_a_z} <= {op.a[0], op.a[1], op.a[2], op.a[3]};
        {s_b_w, s_b_x, s_b_y, s_b_z} <= {op.b[0], op.b[1], op.b[2], op.b[3]};
        s_factor <= op.factor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scoreboard.note_item(op);
        @(negedge aclk);
    endtask

    // Drops valid and waits until every expected result has come.
    task automatic drain_results();
        s_valid <= 0;
        @(negedge aclk);
        while (scoreboard.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                long_hold_req = 0;
            end
            if ($urandom_range(0, 99) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Result sampling at the rising edge.
    always @(posedge aclk) begin
        quat_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got.r[0] = m_r_w;
            got.r[1] = m_r_x;
            got.r[2] = m_r_y;
            got.r[3] = m_r_z;
            got.status = status_t'(m_status);
            scoreboard.check_result(got);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_quaternion_arithmetic_unit failed");
            $finish;
        end
    end

    // Main stimulus.
    initial begin
        logic signed [31:0] extremes [6];
        extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh1_0000, -32'sh1_0000, 1};
        repeat (5) @(negedge aclk);
        aresetn <= 1;

        // Directed: each operation on extreme operands, zero magnitude cases.
        for (int k = 0; k < 8; k++) begin
            send_item(make_op(kind_t'(k), extremes[k % 6], extremes[(k + 1) % 6],
                              extremes[(k + 2) % 6]));
        end
        send_item(make_op(KIND_NORM, 0, 0, 0));
        send_item(make_op(KIND_INV, 0, 0, 0));
        send_item(make_op(KIND_MAG, 32'sh8000_0000, 0, 0));
        send_item(make_op(KIND_CONJ, 32'sh8000_0000, 0, 0));
        send_item(make_op(KIND_MUL, 32'sh8000_0000, 32'sh8000_0000, 0));
        send_item(make_op(KIND_SCALE, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
        send_item(make_op(KIND_INV, 1, 0, 0));
        send_item(make_op(KIND_NORM, 32'sh7FFF_FFFF, 0, 0));
        send_item(make_op(KIND_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_item(make_op(KIND_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));

        // Random, with a long receiver hold-off and a full drain partway.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) long_hold_req = 1;
            if (n == 250) begin
                drain_results();
            end
            send_item(rand_op());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("tb_quaternion_arithmetic_unit passed");
        end else begin
            $display("tb_quaternion_arithmetic_unit failed");
        end
        $finish;
    end

endmodule
